// ===== hdl/hyll_pkg.sv =====
`timescale 1ns / 1ps
package hyll_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [63:0] MIX_MUL       = 64'hc6a4a7935bd1e995;
  localparam int          MIX_SHIFT     = 47;
  localparam logic [63:0] HASH_SEED     = 64'h00000000adc83b19;
  localparam logic [5:0]  RANK_MASK     = 6'h3f;
  localparam logic [5:0]  SUM_FRAC_BITS = 6'd49;
  localparam logic [14:0] ZERO_SAT      = 15'h7fff;

  // One classified item as it travels from the front end to the engine.
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    logic [15:0] len;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

  typedef struct packed {
    logic  avail;
    item_t item;
  } pop_t;

endpackage

// ===== hdl/hyll_front.sv =====
`timescale 1ns / 1ps
module hyll_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_op,
  input  logic [63:0]         in_data_word,
  input  logic [3:0]          in_word_bytes,
  input  logic                in_last_word,
  input  logic [15:0]         in_element_length,
  input  logic                q_full,
  input  logic                init_busy,
  output hyll_pkg::push_t     push_o
);

  logic accept;

  assign in_stall = q_full | init_busy;
  assign accept   = in_valid & ~in_stall;

  // Unknown op codes are taken and dropped; byte counts above eight mean a full word.
  always_comb begin
    push_o.push        = accept & (in_op inside {hyll_pkg::OP_ADD, hyll_pkg::OP_QUERY,
                                                 hyll_pkg::OP_CLEAR});
    push_o.item.op     = in_op;
    push_o.item.word   = in_data_word;
    push_o.item.nbytes = (in_word_bytes > 4'd8) ? 4'd8 : in_word_bytes;
    push_o.item.last   = in_last_word;
    push_o.item.len    = in_element_length;
  end

endmodule

// ===== hdl/hyll_queue.sv =====
`timescale 1ns / 1ps
module hyll_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  hyll_pkg::push_t push_i,
  input  logic            pop,
  output hyll_pkg::pop_t  pop_o,
  output logic            full
);

  hyll_pkg::item_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;

  assign full        = (cnt_r == 2'd2);
  assign pop_o.avail = (cnt_r != 2'd0);
  assign pop_o.item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      mem_r[wp_r] <= push_i.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_i.push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push_i.push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/hyll_back.sv =====
`timescale 1ns / 1ps
module hyll_back #(
  parameter int INDEX_BITS = 14
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hyll_pkg::pop_t pop_i,
  output logic           pop,
  output logic           init_busy,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_result_kind,
  output logic           out_changed,
  output logic [14:0]    out_zero_count,
  output logic [63:0]    out_harmonic_sum
);

  localparam int                DEPTH = 1 << INDEX_BITS;
  localparam logic [INDEX_BITS:0] NREG = (INDEX_BITS + 1)'(DEPTH);
  localparam logic [INDEX_BITS:0] CNT_ONE = (INDEX_BITS + 1)'(1);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SEED = 4'd2;
  localparam logic [3:0] S_MIX  = 4'd3;
  localparam logic [3:0] S_K1   = 4'd4;
  localparam logic [3:0] S_K2   = 4'd5;
  localparam logic [3:0] S_H    = 4'd6;
  localparam logic [3:0] S_END  = 4'd7;
  localparam logic [3:0] S_F    = 4'd8;
  localparam logic [3:0] S_RD   = 4'd9;
  localparam logic [3:0] S_WR   = 4'd10;
  localparam logic [3:0] S_WALK = 4'd11;
  localparam logic [3:0] S_CLR  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]            st_r;
  logic [1:0]            ph_r;
  logic [63:0]           opnd_r, acc_r, acc_nxt, h_r, fin_r;
  logic                  inside_r;
  hyll_pkg::item_t       it_r;
  logic [INDEX_BITS:0]   cnt_r;
  logic                  rdv_r;
  logic [INDEX_BITS:0]   zc_r;
  logic [63:0]           sum_r;
  logic [5:0]            rank_r;
  logic [1:0]            res_kind_r;
  logic                  res_chg_r;

  logic [5:0]            mem [DEPTH];
  logic [5:0]            rd_q;
  logic [INDEX_BITS-1:0] rd_addr, wr_addr;
  logic                  wr_en;
  logic [5:0]            wr_data;

  logic [31:0]           mul_a, mul_b;
  logic [63:0]           mprod;
  logic                  in_mul, mul_done;
  logic [63:0]           kmix, fmix, hfin, tail_mask;
  logic [5:0]            rank_c;
  logic [63:0]           term;
  logic [64:0]           sum_add;
  logic [31:0]           zc_wide;

  // Shared 64x64 (low half) multiplier by the mix constant, one 32x32 partial per cycle.
  assign in_mul   = (st_r == S_SEED) || (st_r == S_K1) || (st_r == S_K2) ||
                    (st_r == S_H) || (st_r == S_F);
  assign mul_done = in_mul && (ph_r == 2'd2);
  assign mul_a    = (ph_r == 2'd1) ? opnd_r[63:32] : opnd_r[31:0];
  assign mul_b    = (ph_r == 2'd2) ? hyll_pkg::MIX_MUL[63:32] : hyll_pkg::MIX_MUL[31:0];
  assign mprod    = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    if (ph_r == 2'd0) begin
      acc_nxt = mprod;
    end else begin
      acc_nxt = {acc_r[63:32] + mprod[31:0], acc_r[31:0]};
    end
  end

  assign kmix = acc_nxt ^ (acc_nxt >> hyll_pkg::MIX_SHIFT);
  assign fmix = acc_nxt ^ (acc_nxt >> hyll_pkg::MIX_SHIFT);
  assign hfin = h_r ^ (h_r >> hyll_pkg::MIX_SHIFT);

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      tail_mask[b*8 +: 8] = (4'(b) < it_r.nbytes) ? 8'hff : 8'h00;
    end
  end

  // Rank: position of the lowest set bit above the index, bit 63 forced on.
  always_comb begin
    rank_c = 6'd0;
    for (int i = 63; i >= INDEX_BITS; i--) begin
      if (fin_r[i] || i == 63) rank_c = 6'(i - INDEX_BITS + 1) & hyll_pkg::RANK_MASK;
    end
  end

  assign term    = (rd_q <= hyll_pkg::SUM_FRAC_BITS) ?
                   (64'd1 << (hyll_pkg::SUM_FRAC_BITS - rd_q)) : 64'd0;
  assign sum_add = {1'b0, sum_r} + {1'b0, term};
  assign zc_wide = 32'(zc_r);

  always_comb begin
    rd_addr = fin_r[INDEX_BITS-1:0];
    if (st_r == S_WALK) rd_addr = cnt_r[INDEX_BITS-1:0];
    wr_addr = cnt_r[INDEX_BITS-1:0];
    wr_data = 6'd0;
    wr_en   = (st_r == S_INIT) || (st_r == S_CLR);
    if (st_r == S_WR) begin
      wr_addr = fin_r[INDEX_BITS-1:0];
      wr_data = rank_r;
      wr_en   = (rank_r > rd_q);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  assign pop       = (st_r == S_IDLE) && pop_i.avail;
  assign init_busy = (st_r == S_INIT);

  always_ff @(posedge clk) begin
    if (in_mul) begin
      acc_r <= acc_nxt;
    end
    if (pop) begin
      it_r <= pop_i.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_INIT;
      ph_r      <= 2'd0;
      cnt_r     <= '0;
      inside_r  <= 1'b0;
      rdv_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && st_r != S_OUT) out_valid <= 1'b0;
      if (in_mul) ph_r <= (ph_r == 2'd2) ? 2'd0 : ph_r + 2'd1;
      case (st_r)
        S_INIT: begin
          cnt_r <= cnt_r + CNT_ONE;
          if (cnt_r[INDEX_BITS-1:0] == '1) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop_i.avail) begin
            cnt_r <= '0;
            zc_r  <= '0;
            sum_r <= '0;
            rdv_r <= 1'b0;
            case (pop_i.item.op)
              hyll_pkg::OP_ADD: begin
                opnd_r <= 64'(pop_i.item.len);
                st_r   <= inside_r ? S_MIX : S_SEED;
              end
              hyll_pkg::OP_QUERY: st_r <= S_WALK;
              default:            st_r <= S_CLR;
            endcase
          end
        end
        S_SEED: begin
          if (mul_done) begin
            h_r      <= hyll_pkg::HASH_SEED ^ acc_nxt;
            inside_r <= 1'b1;
            st_r     <= S_MIX;
          end
        end
        S_MIX: begin
          if (it_r.nbytes == 4'd8) begin
            opnd_r <= it_r.word;
            st_r   <= S_K1;
          end else if (it_r.nbytes != 4'd0) begin
            opnd_r <= h_r ^ (it_r.word & tail_mask);
            st_r   <= S_H;
          end else begin
            st_r <= S_END;
          end
        end
        S_K1: begin
          if (mul_done) begin
            opnd_r <= kmix;
            st_r   <= S_K2;
          end
        end
        S_K2: begin
          if (mul_done) begin
            opnd_r <= h_r ^ acc_nxt;
            st_r   <= S_H;
          end
        end
        S_H: begin
          if (mul_done) begin
            h_r  <= acc_nxt;
            st_r <= S_END;
          end
        end
        S_END: begin
          if (it_r.last) begin
            opnd_r   <= hfin;
            inside_r <= 1'b0;
            st_r     <= S_F;
          end else begin
            st_r <= S_IDLE;
          end
        end
        S_F: begin
          if (mul_done) begin
            fin_r <= fmix;
            st_r  <= S_RD;
          end
        end
        S_RD: begin
          rank_r <= rank_c;
          st_r   <= S_WR;
        end
        S_WR: begin
          res_kind_r <= hyll_pkg::OP_ADD;
          res_chg_r  <= (rank_r > rd_q);
          zc_r       <= '0;
          sum_r      <= '0;
          st_r       <= S_OUT;
        end
        S_WALK: begin
          if (cnt_r != NREG) begin
            cnt_r <= cnt_r + CNT_ONE;
            rdv_r <= 1'b1;
          end else begin
            rdv_r <= 1'b0;
          end
          if (rdv_r) begin
            if (rd_q == 6'd0) zc_r <= zc_r + CNT_ONE;
            sum_r <= sum_add[64] ? '1 : sum_add[63:0];
          end
          if (cnt_r == NREG && !rdv_r) begin
            res_kind_r <= hyll_pkg::OP_QUERY;
            res_chg_r  <= 1'b0;
            st_r       <= S_OUT;
          end
        end
        S_CLR: begin
          cnt_r <= cnt_r + CNT_ONE;
          if (cnt_r[INDEX_BITS-1:0] == '1) begin
            res_kind_r <= hyll_pkg::OP_CLEAR;
            res_chg_r  <= 1'b0;
            zc_r       <= '0;
            sum_r      <= '0;
            st_r       <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            out_result_kind  <= res_kind_r;
            out_changed      <= res_chg_r;
            out_zero_count   <= (zc_wide > 32'(hyll_pkg::ZERO_SAT)) ?
                                hyll_pkg::ZERO_SAT : 15'(zc_r);
            out_harmonic_sum <= sum_r;
            st_r             <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/hyperloglog_dense_sketch.sv =====
`timescale 1ns / 1ps
// An add mixes its bytes into the running hash with the shared 64-bit mix multiplier; a last
// word then also runs the finalizer and the register update.
// A query walks and a clear zeroes all 2^INDEX_BITS registers, one register a cycle.
// Synchronous active-low reset; after reset a clearing pass zeroes the register store,
// and no item is taken until it ends.
module hyperloglog_dense_sketch #(
  parameter int INDEX_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_word_bytes,
  input  logic        in_last_word,
  input  logic [15:0] in_element_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic        out_changed,
  output logic [14:0] out_zero_count,
  output logic [63:0] out_harmonic_sum
);

  // The front end takes each item, drops unknown ops and clamps the byte count.
  // A two-entry queue lets it accept up to two items while the engine is busy.
  hyll_pkg::push_t push_s;
  hyll_pkg::pop_t  pop_s;
  logic            q_full, pop, init_busy;

  hyll_front u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_data_word      (in_data_word),
    .in_word_bytes     (in_word_bytes),
    .in_last_word      (in_last_word),
    .in_element_length (in_element_length),
    .q_full            (q_full),
    .init_busy         (init_busy),
    .push_o            (push_s)
  );

  hyll_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push_s),
    .pop    (pop),
    .pop_o  (pop_s),
    .full   (q_full)
  );

  // The engine runs the hash, updates the register store and walks it for
  // query and clear; its output register holds a result until it is taken.
  hyll_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_i            (pop_s),
    .pop              (pop),
    .init_busy        (init_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_changed      (out_changed),
    .out_zero_count   (out_zero_count),
    .out_harmonic_sum (out_harmonic_sum)
  );

endmodule

// ===== tb/sv/tb_hyperloglog_dense_sketch.sv =====
`timescale 1ns / 1ps
module tb_hyperloglog_dense_sketch;

  localparam int IDX_BITS = 14;
  localparam int NUM_REGS = 1 << IDX_BITS;
  // No item is accepted and no result appears for this many cycles: the run has hung.
  // A query walks the whole store, so the limit must cover several full walks.
  localparam int STALL_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  // Op code that the block does not know; it is taken and dropped.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [63:0] in_data_word;
  logic [3:0]  in_word_bytes;
  logic        in_last_word;
  logic [15:0] in_element_length;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_result_kind;
  logic        out_changed;
  logic [14:0] out_zero_count;
  logic [63:0] out_harmonic_sum;

  hyperloglog_dense_sketch #(.INDEX_BITS(IDX_BITS)) DUT (.*);

  // Clock with a 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One expected result, as the predictor works it out for an accepted item.
  typedef struct {
    logic [1:0]  kind;
    logic        changed;
    logic [14:0] zeros;
    logic [63:0] hsum;
  } sketch_result_t;

  sketch_result_t pending_results[$];

  // Predictor state: a private copy of the register store and the running hash.
  logic [5:0]  shadow_ranks[NUM_REGS];
  logic [63:0] shadow_hash;
  logic        shadow_in_elem;

  int mismatches;
  int results_seen;
  int items_sent;
  int adds_done, queries_done, clears_done;
  int idle_cycles;
  bit timed_out;
  bit hold_results;   // when set, the receiver holds off for a long stretch
  int hold_cycles;

  // Mixes one full 64-bit word the way the engine's hash does.
  function automatic logic [63:0] mix_word(logic [63:0] w);
    logic [63:0] k;
    k = w * hyll_pkg::MIX_MUL;
    k = k ^ (k >> hyll_pkg::MIX_SHIFT);
    k = k * hyll_pkg::MIX_MUL;
    return k;
  endfunction

  // Final avalanche step of the 64-bit hash.
  function automatic logic [63:0] avalanche(logic [63:0] h);
    logic [63:0] f;
    f = h ^ (h >> hyll_pkg::MIX_SHIFT);
    f = f * hyll_pkg::MIX_MUL;
    f = f ^ (f >> hyll_pkg::MIX_SHIFT);
    return f;
  endfunction

  // Rank is one plus the trailing zeros above the index bits, with bit 63 forced on.
  function automatic logic [5:0] rank_above_index(logic [63:0] h);
    logic [63:0] v;
    int cnt;
    v = h | (64'd1 << 63);
    cnt = 1;
    for (int b = IDX_BITS; b < 64; b++) begin
      if (v[b]) break;
      cnt++;
    end
    return cnt[5:0];
  endfunction

  // Works out what one accepted item returns, and whether it returns anything.
  function automatic bit predict_sketch(input logic [1:0] op, input logic [63:0] w,
                                        input logic [3:0] nb, input logic lst,
                                        input logic [15:0] len,
                                        output sketch_result_t res);
    logic [63:0] h;
    logic [63:0] fh;
    logic [63:0] mask;
    logic [63:0] total;
    logic [63:0] term;
    logic [5:0]  r;
    int          idx;
    int          zc;
    res.kind = op;
    res.changed = 1'b0;
    res.zeros = '0;
    res.hsum = '0;
    case (op)
      hyll_pkg::OP_ADD: begin
        if (!shadow_in_elem) begin
          shadow_hash = hyll_pkg::HASH_SEED ^ (64'(len) * hyll_pkg::MIX_MUL);
          shadow_in_elem = 1'b1;
        end
        h = shadow_hash;
        if (nb >= 4'd8) begin
          h = (h ^ mix_word(w)) * hyll_pkg::MIX_MUL;
        end else if (nb != 4'd0) begin
          mask = (64'd1 << (nb * 8)) - 64'd1;
          h = (h ^ (w & mask)) * hyll_pkg::MIX_MUL;
        end
        shadow_hash = h;
        if (!lst) return 1'b0;
        fh = avalanche(h);
        idx = int'(fh[IDX_BITS-1:0]);
        r = rank_above_index(fh);
        if (r > shadow_ranks[idx]) begin
          shadow_ranks[idx] = r;
          res.changed = 1'b1;
        end
        shadow_in_elem = 1'b0;
        shadow_hash = '0;
        return 1'b1;
      end
      hyll_pkg::OP_QUERY: begin
        zc = 0;
        total = '0;
        for (int j = 0; j < NUM_REGS; j++) begin
          if (shadow_ranks[j] == 6'd0) zc++;
          term = (shadow_ranks[j] <= hyll_pkg::SUM_FRAC_BITS) ?
                 (64'd1 << (hyll_pkg::SUM_FRAC_BITS - shadow_ranks[j])) : 64'd0;
          if (total > ~term) total = '1;
          else total = total + term;
        end
        res.zeros = (zc > 32'h7fff) ? hyll_pkg::ZERO_SAT : zc[14:0];
        res.hsum = total;
        return 1'b1;
      end
      hyll_pkg::OP_CLEAR: begin
        foreach (shadow_ranks[j]) shadow_ranks[j] = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offers one item after a random gap, waits for acceptance, and predicts its result.
  // Valid stays high after acceptance; the next gap or the drain task drops it.
  task automatic send_item(logic [1:0] op, logic [63:0] w, logic [3:0] nb, logic lst,
                           logic [15:0] len);
    int gap;
    sketch_result_t res;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_data_word <= w;
    in_word_bytes <= nb;
    in_last_word <= lst;
    in_element_length <= len;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (predict_sketch(op, w, nb, lst, len, res)) begin
      pending_results.push_back(res);
      case (op)
        hyll_pkg::OP_ADD:   adds_done++;
        hyll_pkg::OP_QUERY: queries_done++;
        default:            clears_done++;
      endcase
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Sends a whole element of the given length in full words plus a partial tail.
  task automatic send_element(int nbytes, logic [15:0] len);
    int left;
    left = nbytes;
    if (left == 0) begin
      send_item(hyll_pkg::OP_ADD, rand64(), 4'd0, 1'b1, len);
      return;
    end
    while (left > 0) begin
      send_item(hyll_pkg::OP_ADD, rand64(), (left >= 8) ? 4'd8 : 4'(left), left <= 8, len);
      left -= 8;
    end
  endtask

  // Stops offering items and waits until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 && !timed_out) @(posedge clk);
  endtask

  // Directed: field extremes, every op, and each special case of the front end.
  task automatic test_directed();
    send_item(hyll_pkg::OP_QUERY, '0, '0, 1'b0, '0);                   // empty store
    send_item(hyll_pkg::OP_ADD, '0, 4'd0, 1'b1, 16'd0);                // empty element
    send_item(hyll_pkg::OP_ADD, '1, 4'd8, 1'b1, 16'hffff);             // all ones, full word
    send_item(hyll_pkg::OP_ADD, '0, 4'd8, 1'b1, 16'd8);
    send_item(hyll_pkg::OP_ADD, '1, 4'd15, 1'b1, 16'd8);               // byte count above eight
    // Bytes past the count are masked off.
    send_item(hyll_pkg::OP_ADD, 64'hdead_beef_0bad_f00d, 4'd3, 1'b1, 16'd3);
    send_item(hyll_pkg::OP_ADD, 64'h0123_4567_89ab_cdef, 4'd8, 1'b0, 16'd20);
    // A partial word that is not the last one.
    send_item(hyll_pkg::OP_ADD, 64'hffee_ddcc_bbaa_9988, 4'd5, 1'b0, 16'd20);
    send_item(hyll_pkg::OP_QUERY, '0, '0, 1'b0, '0);                   // query inside an element
    send_item(hyll_pkg::OP_ADD, 64'h5555_aaaa_5555_aaaa, 4'd7, 1'b1, 16'd20);
    send_item(hyll_pkg::OP_ADD, 64'h1, 4'd1, 1'b1, 16'd999);           // length mismatch
    send_item(OP_UNUSED, '1, 4'd8, 1'b1, '1);                          // unknown op is ignored
    send_item(hyll_pkg::OP_ADD, 64'h8000_0000_0000_0000, 4'd8, 1'b0, 16'd9);
    send_item(hyll_pkg::OP_CLEAR, '0, '0, 1'b0, '0);                   // clear inside an element
    send_item(hyll_pkg::OP_ADD, 64'h42, 4'd1, 1'b1, 16'd9);
    send_item(hyll_pkg::OP_QUERY, '0, '0, 1'b0, '0);
    send_item(hyll_pkg::OP_CLEAR, '0, '0, 1'b0, '0);
    send_item(hyll_pkg::OP_QUERY, '0, '0, 1'b0, '0);
    wait_drained();
  endtask

  // Random: mostly well-formed elements with random content, some noise ops.
  task automatic test_random_elements(int count);
    int nbytes;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
        send_element(nbytes, ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'(nbytes));
      end else if (pick < 88) begin
        send_item(hyll_pkg::OP_ADD, rand64(), 4'($urandom_range(0, 15)), 1'($urandom()),
                  16'($urandom()));
      end else if (pick < 91) begin
        send_item(hyll_pkg::OP_QUERY, rand64(), 4'($urandom()), 1'($urandom()),
                  16'($urandom()));
      end else if (pick < 92) begin
        send_item(hyll_pkg::OP_CLEAR, rand64(), 4'($urandom()), 1'($urandom()),
                  16'($urandom()));
      end else begin
        send_item(OP_UNUSED, rand64(), 4'($urandom()), 1'($urandom()), 16'($urandom()));
      end
    end
    send_item(hyll_pkg::OP_QUERY, '0, '0, 1'b0, '0);
    wait_drained();
  endtask

  // Back pressure: the receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    hold_cycles = 600;
    hold_results = 1'b1;
    for (int i = 0; i < 40; i++) send_element($urandom_range(1, 8), 16'd8);
    wait_drained();
  endtask

  // Receiver: a random stall per result, plus the long hold when asked for.
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_results = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && !hold_results);
    end
  end

  // Checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    sketch_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result kind=%0d changed=%0d zeros=%0d sum=%h",
                   out_result_kind, out_changed, out_zero_count, out_harmonic_sum);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_result_kind !== exp_res.kind || out_changed !== exp_res.changed ||
            out_zero_count !== exp_res.zeros || out_harmonic_sum !== exp_res.hsum) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: expected kind=%0d changed=%0d zeros=%0d sum=%h, got %0d %0d %0d %h",
                     exp_res.kind, exp_res.changed, exp_res.zeros, exp_res.hsum,
                     out_result_kind, out_changed, out_zero_count, out_harmonic_sum);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    adds_done = 0;
    queries_done = 0;
    clears_done = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    hold_results = 1'b0;
    hold_cycles = 0;
    shadow_hash = '0;
    shadow_in_elem = 1'b0;
    foreach (shadow_ranks[j]) shadow_ranks[j] = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = hyll_pkg::OP_ADD;
    in_data_word = '0;
    in_word_bytes = '0;
    in_last_word = 1'b0;
    in_element_length = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_elements(900);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d element adds, %0d queries, %0d clears checked,",
             items_sent, adds_done, queries_done, clears_done);
    $display("%0d results compared, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
